// ===== design/aht_pkg.sv =====
// ----------------------------------------------------------------------------
// aht_pkg
// Shared types, widths and helpers for the alarm hold/cooldown table.
// ----------------------------------------------------------------------------
package aht_pkg;

    localparam int TABLE_DEPTH = 96;
    localparam int TIME_BITS   = 32;
    localparam int KEY_BITS    = 9;
    localparam int DUR_BITS    = 27;
    localparam int CMP_BITS    = (TIME_BITS > DUR_BITS) ? TIME_BITS : DUR_BITS;

    typedef logic [TIME_BITS-1:0] tstamp_t;
    typedef logic [KEY_BITS-1:0]  key_t;
    typedef logic [DUR_BITS-1:0]  dur_t;

    typedef struct packed {
        logic [4:0]  rule_index;
        logic [3:0]  instance_index;
        logic        condition_true;
        logic [31:0] now_ms;
        dur_t        hold_ms;
        dur_t        cooldown_ms;
        dur_t        repeat_ms;
    } item_t;

    typedef struct packed {
        logic fire;
        logic no_slot;
        logic holding;
    } result_t;

    typedef struct packed {
        key_t    key;
        logic    holding;
        tstamp_t held_start;
        logic    fired_ever;
        tstamp_t last_fire;
        logic    armed;
    } entry_t;

    // Input time reduced (or widened) to the stored time width.
    function automatic tstamp_t to_tstamp(logic [31:0] v);
        logic [63:0] w;
        w = {32'b0, v};
        return w[TIME_BITS-1:0];
    endfunction

    // elapsed >= duration, both taken as unsigned
    function automatic logic at_least(tstamp_t el, dur_t dur);
        logic [CMP_BITS-1:0] a;
        logic [CMP_BITS-1:0] b;
        a = CMP_BITS'(el);
        b = CMP_BITS'(dur);
        return (a >= b);
    endfunction

endpackage

// ===== design/aht_mem.sv =====
// ----------------------------------------------------------------------------
// aht_mem
// Entry store: one synchronous RAM with a registered read, plus per-entry
// used flags in flops that reset clears.
// ----------------------------------------------------------------------------
module aht_mem #(
    parameter int DEPTH = aht_pkg::TABLE_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rd_en,
    input  logic [AW-1:0]  rd_addr,
    output aht_pkg::entry_t rd_data,
    output logic           rd_used,
    input  logic           wr_en,
    input  logic [AW-1:0]  wr_addr,
    input  aht_pkg::entry_t wr_data
);

    aht_pkg::entry_t mem [DEPTH];
    aht_pkg::entry_t rd_data_reg;
    logic            rd_used_reg;
    logic [DEPTH-1:0] used_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            rd_used_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                used_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_used_reg <= used_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_used = rd_used_reg;

endmodule

// ===== design/aht_eval.sv =====
// ----------------------------------------------------------------------------
// aht_eval
// Hold/cooldown/repeat decision: registers the entry and its elapsed times,
// then forms the updated entry and the fire decision.
// ----------------------------------------------------------------------------
module aht_eval (
    input  logic             clk,
    input  logic             load,
    input  aht_pkg::entry_t  entry,
    input  aht_pkg::tstamp_t now_t,
    input  logic             cond,
    input  aht_pkg::dur_t    hold,
    input  aht_pkg::dur_t    cool,
    input  aht_pkg::dur_t    rep,
    output aht_pkg::entry_t  upd,
    output logic             fire,
    output logic             holding
);

    aht_pkg::entry_t  ent_reg;
    aht_pkg::tstamp_t el_hold_reg;
    aht_pkg::tstamp_t el_last_reg;
    aht_pkg::tstamp_t hs_eff;

    // a fresh hold starts now, so its elapsed time is zero
    assign hs_eff = entry.holding ? entry.held_start : now_t;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ent_reg     <= entry;
            el_hold_reg <= now_t - hs_eff;
            el_last_reg <= now_t - entry.last_fire;
        end
    end

    logic held_long;
    logic due;
    logic cooled;
    logic fire_c;

    always_comb
    begin
        held_long = aht_pkg::at_least(el_hold_reg, hold);
        due       = ent_reg.armed ||
                    ((rep != '0) && aht_pkg::at_least(el_last_reg, rep));
        cooled    = !ent_reg.fired_ever || aht_pkg::at_least(el_last_reg, cool);
        fire_c    = cond && held_long && due && cooled;

        upd = ent_reg;
        if (!cond)
        begin
            upd.holding = 1'b0;
            upd.armed   = 1'b1;
        end
        else
        begin
            upd.holding = 1'b1;
            if (!ent_reg.holding)
            begin
                upd.held_start = now_t;
            end
            if (fire_c)
            begin
                upd.armed      = 1'b0;
                upd.last_fire  = now_t;
                upd.fired_ever = 1'b1;
            end
        end
    end

    assign fire    = fire_c;
    assign holding = cond;

endmodule

// ===== design/alarm_hold_cooldown_table.sv =====
// ----------------------------------------------------------------------------
// alarm_hold_cooldown_table
// Per-channel alarm qualifier with a searched table of hold/cooldown entries.
// ----------------------------------------------------------------------------
// Usage:
//   Present an item on item and raise start; it is taken at a clock edge
//   where start is high and busy is low. busy stays high while the item is
//   worked on. The result appears on result for exactly one cycle with done
//   high; the receiver must take it then, it cannot hold results off.
//   Scan: the table RAM is scanned one entry per cycle from entry 0 through a
//   registered read, stopping at the first key match. A new key costs a full
//   scan and takes the first free entry; a full table skips the update state.
//   The matched or new entry is written back in the update state.
//   The next item can be taken in the cycle done is high.
//   A full table gives no_slot with fire and holding low and leaves the table
//   unchanged. Reset clears all entries (used flags in flops), busy and done;
//   no clearing pass is needed, the block is ready right after reset.
// ----------------------------------------------------------------------------
module alarm_hold_cooldown_table #(
    parameter int TABLE_DEPTH = aht_pkg::TABLE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  aht_pkg::item_t   item,
    output logic             done,
    output aht_pkg::result_t result
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    state_t           state_reg;
    aht_pkg::item_t   item_reg;
    logic [AW-1:0]    issue_idx_reg;
    logic             issue_on_reg;
    logic [AW-1:0]    cmp_idx_reg;
    logic             cmp_valid_reg;
    logic             free_found_reg;
    logic [AW-1:0]    free_idx_reg;
    logic [AW-1:0]    tgt_idx_reg;
    logic             done_reg;
    aht_pkg::result_t result_reg;

    aht_pkg::entry_t  rd_data;
    logic             rd_used;
    logic             rd_en;
    logic             wr_en;
    aht_pkg::entry_t  upd;
    logic             ev_fire;
    logic             ev_holding;

    aht_pkg::key_t    key;
    aht_pkg::tstamp_t now_t;
    aht_pkg::entry_t  fresh;
    logic             hit;
    logic             free_now;
    logic             scan_end;
    logic             ev_load;
    aht_pkg::entry_t  ev_entry;

    assign key   = {item_reg.rule_index, item_reg.instance_index};
    assign now_t = aht_pkg::to_tstamp(item_reg.now_ms);

    always_comb
    begin
        fresh            = '0;
        fresh.key        = key;
        fresh.armed      = 1'b1;
    end

    assign rd_en    = (state_reg == ST_SCAN) && issue_on_reg;
    assign hit      = (state_reg == ST_SCAN) && cmp_valid_reg && rd_used &&
                      (rd_data.key == key);
    assign free_now = cmp_valid_reg && !rd_used;
    assign scan_end = (state_reg == ST_SCAN) && cmp_valid_reg && (cmp_idx_reg == LAST_IDX);
    assign ev_load  = hit || (scan_end && (free_found_reg || free_now));
    assign ev_entry = hit ? rd_data : fresh;
    assign wr_en    = (state_reg == ST_UPDATE);

    aht_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (issue_idx_reg),
        .rd_data (rd_data),
        .rd_used (rd_used),
        .wr_en   (wr_en),
        .wr_addr (tgt_idx_reg),
        .wr_data (upd)
    );

    aht_eval u_eval (
        .clk     (clk),
        .load    (ev_load),
        .entry   (ev_entry),
        .now_t   (now_t),
        .cond    (item_reg.condition_true),
        .hold    (item_reg.hold_ms),
        .cool    (item_reg.cooldown_ms),
        .rep     (item_reg.repeat_ms),
        .upd     (upd),
        .fire    (ev_fire),
        .holding (ev_holding)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            item_reg       <= '0;
            issue_idx_reg  <= '0;
            issue_on_reg   <= 1'b0;
            cmp_idx_reg    <= '0;
            cmp_valid_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            tgt_idx_reg    <= '0;
            done_reg       <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        item_reg       <= item;
                        issue_idx_reg  <= '0;
                        issue_on_reg   <= 1'b1;
                        cmp_valid_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        state_reg      <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    // read pipeline: issue one address, compare the previous one
                    cmp_valid_reg <= issue_on_reg;
                    cmp_idx_reg   <= issue_idx_reg;
                    if (issue_on_reg)
                    begin
                        if (issue_idx_reg == LAST_IDX)
                        begin
                            issue_on_reg <= 1'b0;
                        end
                        else
                        begin
                            issue_idx_reg <= issue_idx_reg + 1'b1;
                        end
                    end
                    if (free_now && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= cmp_idx_reg;
                    end
                    if (hit)
                    begin
                        tgt_idx_reg <= cmp_idx_reg;
                        state_reg   <= ST_UPDATE;
                    end
                    else if (scan_end)
                    begin
                        if (free_found_reg || free_now)
                        begin
                            tgt_idx_reg <= free_found_reg ? free_idx_reg : cmp_idx_reg;
                            state_reg   <= ST_UPDATE;
                        end
                        else
                        begin
                            result_reg.fire    <= 1'b0;
                            result_reg.no_slot <= 1'b1;
                            result_reg.holding <= 1'b0;
                            done_reg           <= 1'b1;
                            state_reg          <= ST_IDLE;
                        end
                    end
                end
                ST_UPDATE:
                begin
                    result_reg.fire    <= ev_fire;
                    result_reg.no_slot <= 1'b0;
                    result_reg.holding <= ev_holding;
                    done_reg           <= 1'b1;
                    state_reg          <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== design/aht_checker.sv =====
// ----------------------------------------------------------------------------
// aht_checker
// Port-level checks for the alarm hold/cooldown table, bound to the top.
// ----------------------------------------------------------------------------
module aht_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input aht_pkg::result_t result
);

    // result only shows once the block has gone idle again
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> !done)
        else $error("result strobe right after accept");

    assert property (@(posedge clk) disable iff (!rst_n)
                     (done && result.no_slot) |-> (!result.fire && !result.holding))
        else $error("no_slot result with fire or holding set");

endmodule

bind alarm_hold_cooldown_table aht_checker u_aht_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
